@@ rtl/clp_pkg.sv @@
package clp_pkg;

  localparam int ADDR_WIDTH = 32;

  localparam logic [7:0] CH_END   = 8'd0;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_PLUS  = 8'd43;
  localparam logic [7:0] CH_COMMA = 8'd44;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;
  localparam logic [7:0] CH_UP_A  = 8'd65;
  localparam logic [7:0] CH_UP_Z  = 8'd90;
  localparam logic [7:0] CH_CASE  = 8'd32;

  localparam logic [2:0] OP_NONE  = 3'd0;
  localparam logic [2:0] OP_FLUSH = 3'd1;
  localparam logic [2:0] OP_MR    = 3'd2;
  localparam logic [2:0] OP_READ  = 3'd3;
  localparam logic [2:0] OP_WRITE = 3'd4;

  localparam logic [1:0] KW_FLUSH = 2'd0;
  localparam logic [1:0] KW_MR    = 2'd1;
  localparam logic [1:0] KW_R     = 2'd2;
  localparam logic [1:0] KW_W     = 2'd3;

  typedef struct packed {
    logic [7:0] lc;
    logic       is_end;
    logic       is_ws;
    logic       is_digit;
    logic       is_sign;
    logic       is_minus;
    logic       is_comma;
    logic [3:0] digit;
  } class_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] address;
    logic [7:0]  data_byte;
  } result_t;

  function automatic logic [2:0] kw_len(input logic [1:0] id);
    logic [2:0] len;
    unique case (id)
      KW_FLUSH: len = 3'd5;
      KW_MR:    len = 3'd2;
      default:  len = 3'd1;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] kw_char(input logic [1:0] id, input logic [2:0] pos);
    logic [7:0] c;
    c = 8'd0;
    unique case (id)
      KW_FLUSH: begin
        case (pos)
          3'd0:    c = "f";
          3'd1:    c = "l";
          3'd2:    c = "u";
          3'd3:    c = "s";
          3'd4:    c = "h";
          default: c = 8'd0;
        endcase
      end
      KW_MR: begin
        case (pos)
          3'd0:    c = "m";
          3'd1:    c = "r";
          default: c = 8'd0;
        endcase
      end
      KW_R: c = (pos == 3'd0) ? 8'("r") : 8'd0;
      default: c = (pos == 3'd0) ? 8'("w") : 8'd0;
    endcase
    return c;
  endfunction

endpackage

@@ rtl/clp_if.sv @@
interface clp_char_if (input logic clk);
  logic       valid;
  logic       ready;
  logic [7:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink (input valid, input ch, output ready);
endinterface

interface clp_result_if (input logic clk);
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [31:0] address;
  logic [7:0]  data_byte;

  modport source (output valid, output cmd, output address, output data_byte, input ready);
  modport sink (input valid, input cmd, input address, input data_byte, output ready);
endinterface

@@ rtl/command_line_parser.sv @@
// A line-ending zero word waits in the input register until the output is free; its result
// word is then registered onto the output.
// Throughput: one character word per cycle, set by the input register feeding the parser.
// Only a line-ending word waits, and only while an earlier result is not yet taken.
// Reset (synchronous, active high) empties both registers and returns to keyword search.
module command_line_parser (
  input logic          clk,
  input logic          rst,
  clp_char_if.sink     chars,
  clp_result_if.source results
);

  logic             in_valid;
  logic [7:0]       in_ch;
  logic             in_is_end;
  logic             out_free;
  logic             step;
  clp_pkg::result_t res;

  assign in_is_end     = (in_ch == clp_pkg::CH_END);
  assign out_free      = !results.valid || results.ready;
  assign step          = in_valid && (!in_is_end || out_free);
  assign chars.ready   = !in_valid || step;

  clp_parser u_parser (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .ch   (in_ch),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (chars.ready) begin
      in_valid <= chars.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (chars.ready && chars.valid) begin
      in_ch <= chars.ch;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (step && in_is_end) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && in_is_end) begin
      results.cmd       <= res.cmd;
      results.address   <= res.address;
      results.data_byte <= res.data_byte;
    end
  end

endmodule

@@ rtl/clp_classify.sv @@
module clp_classify (
  input  logic [7:0]      ch,
  output clp_pkg::class_t cls
);

  always_comb begin
    cls.lc = ch;
    if (ch >= clp_pkg::CH_UP_A && ch <= clp_pkg::CH_UP_Z) begin
      cls.lc = ch + clp_pkg::CH_CASE;
    end
    cls.is_end   = (ch == clp_pkg::CH_END);
    cls.is_ws    = (ch == clp_pkg::CH_SPACE) ||
                   (ch >= clp_pkg::CH_TAB && ch <= clp_pkg::CH_CR);
    cls.is_digit = (ch >= clp_pkg::CH_ZERO && ch <= clp_pkg::CH_NINE);
    cls.is_sign  = (ch == clp_pkg::CH_PLUS) || (ch == clp_pkg::CH_MINUS);
    cls.is_minus = (ch == clp_pkg::CH_MINUS);
    cls.is_comma = (ch == clp_pkg::CH_COMMA);
    cls.digit    = 4'(ch - clp_pkg::CH_ZERO);
  end

endmodule

@@ rtl/clp_parser.sv @@
module clp_parser (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic [7:0]       ch,
  output clp_pkg::result_t res
);

  typedef enum logic [3:0] {
    SEARCH    = 4'd0,
    KEYWORD   = 4'd1,
    FAIL      = 4'd2,
    DONE      = 4'd3,
    ADDR_WS   = 4'd4,
    ADDR_SIGN = 4'd5,
    ADDR_DIG  = 4'd6,
    VAL_WS    = 4'd7,
    VAL_SIGN  = 4'd8,
    VAL_DIG   = 4'd9
  } phase_t;

  clp_pkg::class_t cls;

  phase_t                         phase;
  phase_t                         phase_next;
  logic [1:0]                     keyword_id;
  logic [1:0]                     keyword_id_next;
  logic [2:0]                     keyword_pos;
  logic [2:0]                     keyword_pos_next;
  logic [clp_pkg::ADDR_WIDTH-1:0] addr_acc;
  logic [clp_pkg::ADDR_WIDTH-1:0] addr_acc_next;
  logic [7:0]                     val_acc;
  logic [7:0]                     val_acc_next;
  logic                           negative;
  logic                           negative_next;

  logic [clp_pkg::ADDR_WIDTH-1:0] addr_fin;
  logic [7:0]                     val_fin;
  logic [2:0]                     kw_length;

  clp_classify u_classify (
    .ch  (ch),
    .cls (cls)
  );

  assign addr_fin  = negative ? (~addr_acc + 1'b1) : addr_acc;
  assign val_fin   = negative ? (~val_acc + 1'b1) : val_acc;
  assign kw_length = clp_pkg::kw_len(keyword_id);

  always_comb begin
    phase_next       = phase;
    keyword_id_next  = keyword_id;
    keyword_pos_next = keyword_pos;
    addr_acc_next    = addr_acc;
    val_acc_next     = val_acc;
    negative_next    = negative;
    unique case (phase)
      SEARCH: begin
        if (cls.lc == "f" || cls.lc == "m" || cls.lc == "r" || cls.lc == "w") begin
          if (cls.lc == "f") begin
            keyword_id_next = clp_pkg::KW_FLUSH;
          end else if (cls.lc == "m") begin
            keyword_id_next = clp_pkg::KW_MR;
          end else if (cls.lc == "r") begin
            keyword_id_next = clp_pkg::KW_R;
          end else begin
            keyword_id_next = clp_pkg::KW_W;
          end
          keyword_pos_next = 3'd1;
          phase_next       = KEYWORD;
        end
      end
      KEYWORD: begin
        if (keyword_pos < kw_length &&
            cls.lc == clp_pkg::kw_char(keyword_id, keyword_pos)) begin
          keyword_pos_next = keyword_pos + 3'd1;
        end else if (keyword_pos == kw_length && cls.is_ws) begin
          if (keyword_id == clp_pkg::KW_R || keyword_id == clp_pkg::KW_W) begin
            phase_next = ADDR_WS;
          end else begin
            phase_next = DONE;
          end
        end else begin
          phase_next = FAIL;
        end
      end
      ADDR_WS: begin
        if (cls.is_ws) begin
          phase_next = ADDR_WS;
        end else if (cls.is_sign) begin
          negative_next = cls.is_minus;
          phase_next    = ADDR_SIGN;
        end else if (cls.is_digit) begin
          addr_acc_next = clp_pkg::ADDR_WIDTH'(cls.digit);
          phase_next    = ADDR_DIG;
        end else if (cls.is_comma && keyword_id == clp_pkg::KW_W) begin
          phase_next = VAL_WS;
        end else begin
          phase_next = FAIL;
        end
      end
      ADDR_SIGN: begin
        if (cls.is_digit) begin
          addr_acc_next = clp_pkg::ADDR_WIDTH'(cls.digit);
          phase_next    = ADDR_DIG;
        end else begin
          phase_next = FAIL;
        end
      end
      ADDR_DIG: begin
        if (cls.is_digit) begin
          addr_acc_next = (addr_acc << 3) + (addr_acc << 1) +
                          clp_pkg::ADDR_WIDTH'(cls.digit);
        end else if (keyword_id == clp_pkg::KW_R && cls.is_ws) begin
          addr_acc_next = addr_fin;
          negative_next = 1'b0;
          phase_next    = DONE;
        end else if (keyword_id == clp_pkg::KW_W && cls.is_comma) begin
          addr_acc_next = addr_fin;
          negative_next = 1'b0;
          phase_next    = VAL_WS;
        end else begin
          phase_next = FAIL;
        end
      end
      VAL_WS: begin
        if (cls.is_ws) begin
          phase_next = VAL_WS;
        end else if (cls.is_sign) begin
          negative_next = cls.is_minus;
          phase_next    = VAL_SIGN;
        end else if (cls.is_digit) begin
          val_acc_next = 8'(cls.digit);
          phase_next   = VAL_DIG;
        end else begin
          phase_next = FAIL;
        end
      end
      VAL_SIGN: begin
        if (cls.is_digit) begin
          val_acc_next = 8'(cls.digit);
          phase_next   = VAL_DIG;
        end else begin
          phase_next = FAIL;
        end
      end
      VAL_DIG: begin
        if (cls.is_digit) begin
          val_acc_next = (val_acc << 3) + (val_acc << 1) + 8'(cls.digit);
        end else if (cls.is_ws) begin
          val_acc_next  = val_fin;
          negative_next = 1'b0;
          phase_next    = DONE;
        end else begin
          phase_next = FAIL;
        end
      end
      FAIL: begin
        phase_next = phase;
      end
      DONE: begin
        phase_next = phase;
      end
      default: begin
        phase_next = FAIL;
      end
    endcase
  end

  always_comb begin
    res.cmd       = clp_pkg::OP_NONE;
    res.address   = 32'd0;
    res.data_byte = 8'd0;
    if (phase == DONE) begin
      res.cmd = 3'(keyword_id) + 3'd1;
      if (keyword_id == clp_pkg::KW_R || keyword_id == clp_pkg::KW_W) begin
        res.address = 32'(addr_acc);
      end
      if (keyword_id == clp_pkg::KW_W) begin
        res.data_byte = val_acc;
      end
    end else if (phase == ADDR_DIG && keyword_id == clp_pkg::KW_R) begin
      res.cmd     = clp_pkg::OP_READ;
      res.address = 32'(addr_fin);
    end else if (phase == VAL_WS || phase == VAL_DIG) begin
      res.cmd       = clp_pkg::OP_WRITE;
      res.address   = 32'(addr_acc);
      res.data_byte = val_fin;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (step && cls.is_end)) begin
      phase       <= SEARCH;
      keyword_id  <= clp_pkg::KW_FLUSH;
      keyword_pos <= 3'd0;
      addr_acc    <= '0;
      val_acc     <= 8'd0;
      negative    <= 1'b0;
    end else if (step) begin
      phase       <= phase_next;
      keyword_id  <= keyword_id_next;
      keyword_pos <= keyword_pos_next;
      addr_acc    <= addr_acc_next;
      val_acc     <= val_acc_next;
      negative    <= negative_next;
    end
  end

endmodule

@@ rtl/clp_checker.sv @@
module clp_checker (
  input logic        clk,
  input logic        rst,
  input logic        chars_valid,
  input logic        chars_ready,
  input logic        results_valid,
  input logic        results_ready,
  input logic [2:0]  results_cmd,
  input logic [31:0] results_address,
  input logic [7:0]  results_data_byte
);

  // A stalled result word must hold its contents.
  assert property (@(posedge clk) disable iff (rst)
    results_valid && !results_ready |=>
      results_valid && $stable(results_cmd) && $stable(results_address) &&
      $stable(results_data_byte))
    else $error("result word changed while stalled");

  assert property (@(posedge clk) disable iff (rst)
    results_valid |-> results_cmd <= clp_pkg::OP_WRITE)
    else $error("command code out of range");

  assert property (@(posedge clk) disable iff (rst)
    results_valid && (results_cmd == clp_pkg::OP_NONE ||
      results_cmd == clp_pkg::OP_FLUSH || results_cmd == clp_pkg::OP_MR) |->
      results_address == 32'd0 && results_data_byte == 8'd0)
    else $error("address or data present on a command without operands");

  assert property (@(posedge clk) disable iff (rst)
    results_valid && results_cmd == clp_pkg::OP_READ |-> results_data_byte == 8'd0)
    else $error("data byte present on a read");

  // With no result pending, the input side must never stall.
  assert property (@(posedge clk) disable iff (rst)
    !results_valid && chars_valid && $past(!results_valid) |-> chars_ready)
    else $error("input stalled while the output was empty");

endmodule

bind command_line_parser clp_checker u_clp_checker (
  .clk               (clk),
  .rst               (rst),
  .chars_valid       (chars.valid),
  .chars_ready       (chars.ready),
  .results_valid     (results.valid),
  .results_ready     (results.ready),
  .results_cmd       (results.cmd),
  .results_address   (results.address),
  .results_data_byte (results.data_byte)
);

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;

  localparam int LIMIT = 200000;

  typedef enum logic [3:0] {
    P_SEARCH, P_KEYWORD, P_FAIL, P_DONE, P_ADDR_WS, P_ADDR_SIGN, P_ADDR_DIG,
    P_VAL_WS, P_VAL_SIGN, P_VAL_DIG
  } parse_phase_t;

  typedef struct {
    string            text;
    bit               typed;
    clp_pkg::result_t want;
  } line_row_t;

  logic clk;
  logic rst;

  clp_char_if   chars_if (clk);
  clp_result_if results_if (clk);

  command_line_parser dut (
    .clk     (clk),
    .rst     (rst),
    .chars   (chars_if),
    .results (results_if)
  );

  parse_phase_t                   ph;
  logic [1:0]                     kw;
  logic [2:0]                     kpos;
  logic [clp_pkg::ADDR_WIDTH-1:0] acc_addr;
  logic [7:0]                     acc_val;
  logic                           neg;
  string                          kw_spelling [4] = '{"flush", "mr", "r", "w"};

  clp_pkg::result_t awaited_cmds [$];
  logic [7:0]       line_chars [$];
  line_row_t        rows [$];
  int               mismatches = 0;
  int               cycles = 0;
  int               sent = 0;
  bit               steady = 1'b0;

  function automatic bit is_space(input logic [7:0] c);
    return c == clp_pkg::CH_SPACE || (c >= clp_pkg::CH_TAB && c <= clp_pkg::CH_CR);
  endfunction

  function automatic bit is_num(input logic [7:0] c);
    return c >= clp_pkg::CH_ZERO && c <= clp_pkg::CH_NINE;
  endfunction

  function automatic bit is_sign(input logic [7:0] c);
    return c == clp_pkg::CH_PLUS || c == clp_pkg::CH_MINUS;
  endfunction

  function automatic void clear_parser();
    ph = P_SEARCH;
    kw = clp_pkg::KW_FLUSH;
    kpos = '0;
    acc_addr = '0;
    acc_val = '0;
    neg = 1'b0;
  endfunction

  // Advances the parser by one character; returns 1 when a line ends.
  function automatic bit decode_char(input logic [7:0] c, output clp_pkg::result_t r);
    logic [7:0] lc;
    int         len;
    lc = (c >= clp_pkg::CH_UP_A && c <= clp_pkg::CH_UP_Z) ? 8'(c + clp_pkg::CH_CASE) : c;
    len = kw_spelling[kw].len();
    r = '{clp_pkg::OP_NONE, 32'd0, 8'd0};
    if (c == clp_pkg::CH_END) begin
      if (ph == P_DONE) begin
        case (kw)
          clp_pkg::KW_FLUSH: r.cmd = clp_pkg::OP_FLUSH;
          clp_pkg::KW_MR:    r.cmd = clp_pkg::OP_MR;
          clp_pkg::KW_R:     r.cmd = clp_pkg::OP_READ;
          default:           r.cmd = clp_pkg::OP_WRITE;
        endcase
      end else if (ph == P_ADDR_DIG && kw == clp_pkg::KW_R) begin
        if (neg) acc_addr = -acc_addr;
        r.cmd = clp_pkg::OP_READ;
      end else if (ph == P_VAL_WS || ph == P_VAL_DIG) begin
        if (neg) acc_val = -acc_val;
        r.cmd = clp_pkg::OP_WRITE;
      end
      if (r.cmd == clp_pkg::OP_READ || r.cmd == clp_pkg::OP_WRITE) r.address = 32'(acc_addr);
      if (r.cmd == clp_pkg::OP_WRITE) r.data_byte = acc_val;
      clear_parser();
      return 1'b1;
    end
    case (ph)
      P_SEARCH: begin
        if (lc == "f" || lc == "m" || lc == "r" || lc == "w") begin
          kw = (lc == "f") ? clp_pkg::KW_FLUSH : (lc == "m") ? clp_pkg::KW_MR :
               (lc == "r") ? clp_pkg::KW_R : clp_pkg::KW_W;
          kpos = 3'd1;
          ph = P_KEYWORD;
        end
      end
      P_KEYWORD: begin
        if (kpos < len && lc == 8'(kw_spelling[kw][kpos])) begin
          kpos = kpos + 3'd1;
        end else if (kpos == len && is_space(lc)) begin
          ph = (kw == clp_pkg::KW_R || kw == clp_pkg::KW_W) ? P_ADDR_WS : P_DONE;
        end else begin
          ph = P_FAIL;
        end
      end
      P_ADDR_WS: begin
        if (is_sign(c)) begin
          neg = (c == clp_pkg::CH_MINUS);
          ph = P_ADDR_SIGN;
        end else if (is_num(c)) begin
          acc_addr = clp_pkg::ADDR_WIDTH'(c - clp_pkg::CH_ZERO);
          ph = P_ADDR_DIG;
        end else if (c == clp_pkg::CH_COMMA && kw == clp_pkg::KW_W) begin
          ph = P_VAL_WS;
        end else if (!is_space(c)) begin
          ph = P_FAIL;
        end
      end
      P_ADDR_SIGN: begin
        if (is_num(c)) begin
          acc_addr = clp_pkg::ADDR_WIDTH'(c - clp_pkg::CH_ZERO);
          ph = P_ADDR_DIG;
        end else begin
          ph = P_FAIL;
        end
      end
      P_ADDR_DIG: begin
        if (is_num(c)) begin
          acc_addr = clp_pkg::ADDR_WIDTH'(acc_addr * 10 +
                                          clp_pkg::ADDR_WIDTH'(c - clp_pkg::CH_ZERO));
        end else if ((kw == clp_pkg::KW_R && is_space(c)) ||
                     (kw == clp_pkg::KW_W && c == clp_pkg::CH_COMMA)) begin
          if (neg) acc_addr = -acc_addr;
          neg = 1'b0;
          ph = (kw == clp_pkg::KW_R) ? P_DONE : P_VAL_WS;
        end else begin
          ph = P_FAIL;
        end
      end
      P_VAL_WS: begin
        if (is_sign(c)) begin
          neg = (c == clp_pkg::CH_MINUS);
          ph = P_VAL_SIGN;
        end else if (is_num(c)) begin
          acc_val = c - clp_pkg::CH_ZERO;
          ph = P_VAL_DIG;
        end else if (!is_space(c)) begin
          ph = P_FAIL;
        end
      end
      P_VAL_SIGN: begin
        if (is_num(c)) begin
          acc_val = c - clp_pkg::CH_ZERO;
          ph = P_VAL_DIG;
        end else begin
          ph = P_FAIL;
        end
      end
      P_VAL_DIG: begin
        if (is_num(c)) begin
          acc_val = 8'(acc_val * 10 + (c - clp_pkg::CH_ZERO));
        end else if (is_space(c)) begin
          if (neg) acc_val = -acc_val;
          neg = 1'b0;
          ph = P_DONE;
        end else begin
          ph = P_FAIL;
        end
      end
      default: begin
      end
    endcase
    return 1'b0;
  endfunction

  function automatic logic [7:0] pick_space();
    int r;
    r = $urandom_range(0, 7);
    return (r < 5) ? 8'(clp_pkg::CH_TAB + r) : clp_pkg::CH_SPACE;
  endfunction

  function automatic logic [7:0] pick_filler();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(1, 255));
    end while ((c | clp_pkg::CH_CASE) == "f" || (c | clp_pkg::CH_CASE) == "m" ||
               (c | clp_pkg::CH_CASE) == "r" || (c | clp_pkg::CH_CASE) == "w");
    return c;
  endfunction

  task automatic push_number(input int most);
    if ($urandom_range(0, 2) == 0)
      line_chars.push_back($urandom_range(0, 1) ? clp_pkg::CH_MINUS : clp_pkg::CH_PLUS);
    repeat ($urandom_range(1, most))
      line_chars.push_back(8'(clp_pkg::CH_ZERO + $urandom_range(0, 9)));
  endtask

  task automatic send_word(input logic [7:0] c, input bit typed, input clp_pkg::result_t want);
    clp_pkg::result_t got;
    while (!steady && $urandom_range(0, 99) < 26) begin
      chars_if.valid <= 1'b0;
      @(posedge clk);
    end
    chars_if.valid <= 1'b1;
    chars_if.ch <= c;
    do @(posedge clk); while (!chars_if.ready);
    sent++;
    if (decode_char(c, got)) awaited_cmds.push_back(typed ? want : got);
  endtask

  task automatic drain();
    chars_if.valid <= 1'b0;
    @(posedge clk);
    while (awaited_cmds.size() != 0) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("** command_line_parser: FAILED **");
      $finish;
    end
  end

  initial begin
    results_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      results_if.ready <= !rst && (steady || $urandom_range(0, 99) >= 26);
    end
  end

  always @(posedge clk) begin : check_results
    clp_pkg::result_t want;
    clp_pkg::result_t got;
    if (!rst && results_if.valid && results_if.ready) begin
      got = '{results_if.cmd, results_if.address, results_if.data_byte};
      if (awaited_cmds.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected word: cmd %0d address %h byte %h",
                   got.cmd, got.address, got.data_byte);
      end else begin
        want = awaited_cmds.pop_front();
        if (got.cmd !== want.cmd || got.address !== want.address ||
            got.data_byte !== want.data_byte) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected cmd %0d address %h byte %h, got cmd %0d address %h byte %h",
                     want.cmd, want.address, want.data_byte,
                     got.cmd, got.address, got.data_byte);
        end
      end
    end
  end

  initial begin
    int               base;
    int               pick;
    bit               paused;
    logic [1:0]       kind;
    clp_pkg::result_t none;
    none = '{clp_pkg::OP_NONE, 32'd0, 8'd0};
    paused = 1'b0;
    clear_parser();
    rst <= 1'b1;
    chars_if.valid <= 1'b0;
    chars_if.ch <= clp_pkg::CH_END;
    rows = '{
      '{"",                 1'b1, '{clp_pkg::OP_NONE,  32'd0,         8'd0}},
      '{"flush ",           1'b1, '{clp_pkg::OP_FLUSH, 32'd0,         8'd0}},
      '{"FLUSH\tjunk",      1'b1, '{clp_pkg::OP_FLUSH, 32'd0,         8'd0}},
      '{"flush",            1'b1, '{clp_pkg::OP_NONE,  32'd0,         8'd0}},
      '{"flusx ",           1'b1, '{clp_pkg::OP_NONE,  32'd0,         8'd0}},
      '{"xx mr\n",          1'b1, '{clp_pkg::OP_MR,    32'd0,         8'd0}},
      '{"Mr\r+",            1'b1, '{clp_pkg::OP_MR,    32'd0,         8'd0}},
      '{"\377flush ",       1'b0, none},
      '{"r 4294967295",     1'b1, '{clp_pkg::OP_READ,  32'hFFFF_FFFF, 8'd0}},
      '{"r -1 ",            1'b1, '{clp_pkg::OP_READ,  32'hFFFF_FFFF, 8'd0}},
      '{"r +0",             1'b1, '{clp_pkg::OP_READ,  32'd0,         8'd0}},
      '{"r 4294967296",     1'b0, none},
      '{"r \v\f99 trailing", 1'b1, '{clp_pkg::OP_READ, 32'd99,        8'd0}},
      '{"r",                1'b1, '{clp_pkg::OP_NONE,  32'd0,         8'd0}},
      '{"r -",              1'b1, '{clp_pkg::OP_NONE,  32'd0,         8'd0}},
      '{"r 12x",            1'b1, '{clp_pkg::OP_NONE,  32'd0,         8'd0}},
      '{"r ,",              1'b1, '{clp_pkg::OP_NONE,  32'd0,         8'd0}},
      '{"rx 5",             1'b1, '{clp_pkg::OP_NONE,  32'd0,         8'd0}},
      '{"w 10,255",         1'b1, '{clp_pkg::OP_WRITE, 32'd10,        8'd255}},
      '{"W -5,-1 ",         1'b1, '{clp_pkg::OP_WRITE, 32'hFFFF_FFFB, 8'd255}},
      '{"w ,",              1'b1, '{clp_pkg::OP_WRITE, 32'd0,         8'd0}},
      '{"w 7,  ",           1'b1, '{clp_pkg::OP_WRITE, 32'd7,         8'd0}},
      '{"w 7",              1'b1, '{clp_pkg::OP_NONE,  32'd0,         8'd0}},
      '{"w 3 ,4",           1'b1, '{clp_pkg::OP_NONE,  32'd0,         8'd0}},
      '{"w 3,256",          1'b0, none},
      '{"w 3,,1",           1'b1, '{clp_pkg::OP_NONE,  32'd0,         8'd0}},
      '{"w 3, -",           1'b1, '{clp_pkg::OP_NONE,  32'd0,         8'd0}}
    };
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[k]) begin
      for (int i = 0; i < rows[k].text.len(); i++) send_word(8'(rows[k].text[i]), 1'b0, none);
      send_word(clp_pkg::CH_END, rows[k].typed, rows[k].want);
    end
    drain();

    base = sent;
    while (sent < base + 760) begin
      if (!paused && sent >= base + 300) begin
        drain();
        paused = 1'b1;
      end
      steady <= (sent >= base + 450 && sent < base + 650);
      line_chars.delete();
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        repeat ($urandom_range(0, 12)) line_chars.push_back(8'($urandom_range(1, 255)));
      end else begin
        kind = 2'($urandom_range(0, 3));
        if ($urandom_range(0, 1)) repeat ($urandom_range(1, 3)) line_chars.push_back(pick_filler());
        for (int i = 0; i < kw_spelling[kind].len(); i++)
          line_chars.push_back(8'(kw_spelling[kind][i]) -
                               ($urandom_range(0, 1) ? clp_pkg::CH_CASE : 8'd0));
        line_chars.push_back(pick_space());
        if (kind == clp_pkg::KW_R || kind == clp_pkg::KW_W) begin
          repeat ($urandom_range(0, 2)) line_chars.push_back(pick_space());
          if (kind == clp_pkg::KW_R || $urandom_range(0, 9) != 0)
            push_number(($urandom_range(0, 7) == 0) ? 12 : 6);
          if (kind == clp_pkg::KW_W) begin
            line_chars.push_back(clp_pkg::CH_COMMA);
            repeat ($urandom_range(0, 2)) line_chars.push_back(pick_space());
            if ($urandom_range(0, 4) != 0) push_number(4);
          end
        end
        if ($urandom_range(0, 2) == 0) begin
          line_chars.push_back(pick_space());
          repeat ($urandom_range(0, 4)) line_chars.push_back(8'($urandom_range(1, 255)));
        end
        if ($urandom_range(0, 9) == 0)
          line_chars[$urandom_range(0, line_chars.size() - 1)] = 8'($urandom_range(1, 255));
        else if ($urandom_range(0, 19) == 0)
          repeat ($urandom_range(1, line_chars.size())) void'(line_chars.pop_back());
      end
      foreach (line_chars[i]) send_word(line_chars[i], 1'b0, none);
      send_word(clp_pkg::CH_END, 1'b0, none);
    end

    steady <= 1'b0;
    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && awaited_cmds.size() == 0) begin
      $display("** command_line_parser: PASSED **");
    end else begin
      $display("** command_line_parser: FAILED **");
    end
    $finish;
  end

endmodule
